// File: rtl/core/assert_macros.svh
// assertion macros used by bracket_balance_checker
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define BBC_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// implication checked from one edge to the next
`define BBC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/bbc_pkg.sv
// constants, types and decode functions for the bracket balance checker
// no dependencies
package bbc_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int LEVEL_W     = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);

    typedef enum logic [1:0] {
        KIND_PAREN  = 2'd0,
        KIND_SQUARE = 2'd1,
        KIND_BRACE  = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        VERDICT_VALID    = 2'd0,
        VERDICT_INVALID  = 2'd1,
        VERDICT_OVERFLOW = 2'd2
    } verdict_t;

    localparam logic [7:0] CH_OPEN_PAREN   = 8'h28;
    localparam logic [7:0] CH_CLOSE_PAREN  = 8'h29;
    localparam logic [7:0] CH_OPEN_SQUARE  = 8'h5B;
    localparam logic [7:0] CH_CLOSE_SQUARE = 8'h5D;
    localparam logic [7:0] CH_OPEN_BRACE   = 8'h7B;
    localparam logic [7:0] CH_CLOSE_BRACE  = 8'h7D;

    // kind of an opening bracket, none for any other byte
    function automatic kind_t open_kind(input logic [7:0] ch);
        kind_t k;
        case (ch)
            CH_OPEN_PAREN:  k = KIND_PAREN;
            CH_OPEN_SQUARE: k = KIND_SQUARE;
            CH_OPEN_BRACE:  k = KIND_BRACE;
            default:        k = KIND_NONE;
        endcase
        return k;
    endfunction

    // kind of a closing bracket, none for any other byte
    function automatic kind_t close_kind(input logic [7:0] ch);
        kind_t k;
        case (ch)
            CH_CLOSE_PAREN:  k = KIND_PAREN;
            CH_CLOSE_SQUARE: k = KIND_SQUARE;
            CH_CLOSE_BRACE:  k = KIND_BRACE;
            default:         k = KIND_NONE;
        endcase
        return k;
    endfunction

endpackage

// File: rtl/core/bbc_if.sv
// stream interfaces for the character input and the verdict output
// depends on bbc_pkg
interface bbc_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_char;
    logic       last_char;

    modport source (output valid, output in_char, output last_char, input ready);
    modport sink (input valid, input in_char, input last_char, output ready);
endinterface

interface bbc_verdict_if;
    import bbc_pkg::*;
    logic       valid;
    logic       ready;
    logic [1:0] verdict;

    modport source (output valid, output verdict, input ready);
    modport sink (input valid, input verdict, output ready);
endinterface

// File: rtl/core/bracket_balance_checker.sv
// the verdict is registered in the output register, or in the skid entry while a verdict waits there
// one character per cycle while the skid entry is empty; push and pop go to the stack memory, with
//   the top entry held in a register and the entry below it read ahead
// a two-entry output buffer lets input continue while one verdict waits
// reset clears the stack level, the fault flags and the output buffer; the stack memory
//   itself is not cleared, as only entries already written are ever read
`include "assert_macros.svh"

module bracket_balance_checker
    import bbc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    bbc_char_if.sink     char_stream,
    bbc_verdict_if.source verdict_stream
);

    // stack memory, one read port registered, one write port
    kind_t              kind_mem [STACK_DEPTH];
    kind_t              rd_data_reg;
    logic [ADDR_W-1:0]  rd_addr;
    logic [ADDR_W-1:0]  wr_addr;
    logic               wr_en;

    // stack control state
    logic [LEVEL_W-1:0] level_reg, level_next, level_step;
    kind_t              top_reg, top_next;
    logic               error_reg, error_next;
    logic               overflow_reg, overflow_next;
    logic               error_step, overflow_step;

    // output buffer
    logic               out_valid_reg;
    logic [1:0]         out_verdict_reg;
    logic               skid_valid_reg;
    logic [1:0]         skid_verdict_reg;

    logic               in_fire;
    logic               res_fire;
    logic               out_take;
    kind_t              ok;
    kind_t              ck;
    verdict_t           result;

    assign char_stream.ready = !skid_valid_reg;
    assign in_fire           = char_stream.valid && char_stream.ready;
    assign res_fire          = in_fire && char_stream.last_char;
    assign out_take          = out_valid_reg && verdict_stream.ready;

    assign ok = open_kind(char_stream.in_char);
    assign ck = close_kind(char_stream.in_char);

    // push, pop and fault detection for the current character
    always_comb
    begin
        level_step    = level_reg;
        top_next      = top_reg;
        error_step    = error_reg;
        overflow_step = overflow_reg;
        wr_en         = 1'b0;
        wr_addr       = level_reg[ADDR_W-1:0];
        if (in_fire && !error_reg && !overflow_reg)
        begin
            if (ok != KIND_NONE)
            begin
                if (level_reg >= LEVEL_W'(STACK_DEPTH))
                begin
                    overflow_step = 1'b1;
                end
                else
                begin
                    wr_en      = 1'b1;
                    top_next   = ok;
                    level_step = level_reg + LEVEL_W'(1);
                end
            end
            else if (ck != KIND_NONE)
            begin
                if (level_reg == '0)
                begin
                    error_step = 1'b1;
                end
                else
                begin
                    level_step = level_reg - LEVEL_W'(1);
                    top_next   = rd_data_reg;
                    if (top_reg != ck)
                    begin
                        error_step = 1'b1;
                    end
                end
            end
        end
    end

    // verdict from the state after this character, then clear for the next string
    always_comb
    begin
        if (overflow_step)
        begin
            result = VERDICT_OVERFLOW;
        end
        else if (error_step || level_step != '0)
        begin
            result = VERDICT_INVALID;
        end
        else
        begin
            result = VERDICT_VALID;
        end
        level_next    = level_step;
        error_next    = error_step;
        overflow_next = overflow_step;
        if (res_fire)
        begin
            level_next    = '0;
            error_next    = 1'b0;
            overflow_next = 1'b0;
        end
    end

    // read ahead the entry that lies below the next top
    assign rd_addr = ADDR_W'(level_next - LEVEL_W'(2));

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            kind_mem[wr_addr] <= ok;
        end
        rd_data_reg <= kind_mem[rd_addr];
    end

    // stack level and fault flags with reset, cached top without reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg    <= '0;
            error_reg    <= 1'b0;
            overflow_reg <= 1'b0;
        end
        else
        begin
            level_reg    <= level_next;
            error_reg    <= error_next;
            overflow_reg <= overflow_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg <= top_next;
    end

    // output register with skid entry, skid holds the younger verdict
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_take)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= res_fire;
            end
        end
        else if (res_fire)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_take)
        begin
            if (skid_valid_reg)
            begin
                out_verdict_reg <= skid_verdict_reg;
            end
            else if (res_fire)
            begin
                out_verdict_reg <= result;
            end
        end
        else if (res_fire)
        begin
            skid_verdict_reg <= result;
        end
    end

    assign verdict_stream.valid   = out_valid_reg;
    assign verdict_stream.verdict = out_verdict_reg;

    // checks
    `BBC_ASSERT_ALWAYS(a_level_bound, clk, rst_n, level_reg <= LEVEL_W'(STACK_DEPTH),
        "stack level beyond depth")
    `BBC_ASSERT_NEXT(a_clear_after_last, clk, rst_n, res_fire,
        level_reg == '0 && !error_reg && !overflow_reg, "string state not cleared")
    `BBC_ASSERT_ALWAYS(a_skid_order, clk, rst_n, !skid_valid_reg || out_valid_reg,
        "skid entry held with empty output register")
    `BBC_ASSERT_NEXT(a_frozen_after_fault, clk, rst_n,
        (error_reg || overflow_reg) && !res_fire, level_reg == $past(level_reg),
        "stack moved after a fault")

endmodule
